/* hdl/assert_macros.svh */
// Assertion helpers, included by typed_length_frame_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define TLFP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define TLFP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tlfp_pkg.sv */
// ----------------------------------------------------------------------------
// tlfp_pkg
// Types and constants of the typed length frame parser: register indexes,
// reset defaults, result status codes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tlfp_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_CODE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_CODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_LENGTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_POSITION  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_POSITION = 3'd6;

   localparam logic [7:0] RST_START_BYTE     = 8'd0;
   localparam logic [7:0] RST_LED_CODE       = 8'd1;
   localparam logic [7:0] RST_STATUS_CODE    = 8'd2;
   localparam logic [7:0] RST_SERIAL_CODE    = 8'd3;
   localparam logic [4:0] RST_LED_LENGTH     = 5'd2;
   localparam logic [3:0] RST_RATE_POSITION  = 4'd0;
   localparam logic [3:0] RST_COUNT_POSITION = 4'd1;

   localparam logic [1:0] RSP_NONE   = 2'd0;
   localparam logic [1:0] RSP_ACCEPT = 2'd1;
   localparam logic [1:0] RSP_ERROR  = 2'd2;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_CODE,
      ST_LEN,
      ST_DATA,
      ST_CHK_RATE,
      ST_CHK_COUNT,
      ST_CHK_END,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   // What goes into the result register this cycle
   typedef enum logic [2:0] {
      LD_NONE,
      LD_IDLE,
      LD_ERROR,
      LD_EMPTY,
      LD_BYTE
   } load_type;

   typedef enum logic [1:0] {
      RD_RATE,
      RD_COUNT,
      RD_EMIT
   } rdsel_type;

   typedef struct packed {
      logic      take_code;
      logic      take_len;
      logic      write_byte;
      logic      clear;
      logic      rd_en;
      rdsel_type rd_sel;
      logic      cap_rate;
      logic      idx_clr;
      logic      idx_inc;
      load_type  load;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic known;
      logic held_led;
      logic len_ok;
      logic len_zero;
      logic frame_done;
      logic chk_ok;
      logic idx_last;
      logic out_free;
   } sts_type;

endpackage

/* hdl/tlfp_dpath.sv */
// ----------------------------------------------------------------------------
// tlfp_dpath
// Datapath: configuration registers, frame header registers, payload
// buffer with one registered read port, and the result register.
// ----------------------------------------------------------------------------
module tlfp_dpath #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [tlfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tlfp_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [7:0]                          rx_byte,
   input  tlfp_pkg::cmd_type                   cmd,
   output tlfp_pkg::sts_type                   sts,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [7:0]                          rsp_message_code,
   output logic [4:0]                          rsp_frame_length,
   output logic [3:0]                          rsp_byte_index,
   output logic [7:0]                          rsp_payload_byte,
   output logic                                rsp_last
);

   // Lengths never exceed 31, so entries above that are never touched
   localparam int DEPTH = (MAX_PAYLOAD < 32) ? MAX_PAYLOAD : 32;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0] start_byte_ff, led_code_ff, status_code_ff, serial_code_ff;
   logic [4:0] led_length_ff;
   logic [3:0] rate_pos_ff, count_pos_ff;

   logic [7:0] held_code_ff, held_code_in;
   logic [4:0] expected_ff, expected_in;
   logic [4:0] fill_ff, fill_in;
   logic [4:0] idx_ff, idx_in;
   logic [4:0] fill_nxt, idx_nxt;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;
   logic [4:0] rd_addr;
   logic       rate_ok_ff;
   logic       rate_pos_ok, count_pos_ok;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_code_ff;
   logic [4:0] rsp_len_ff;
   logic [3:0] rsp_idx_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= tlfp_pkg::RST_START_BYTE;
         led_code_ff    <= tlfp_pkg::RST_LED_CODE;
         status_code_ff <= tlfp_pkg::RST_STATUS_CODE;
         serial_code_ff <= tlfp_pkg::RST_SERIAL_CODE;
         led_length_ff  <= tlfp_pkg::RST_LED_LENGTH;
         rate_pos_ff    <= tlfp_pkg::RST_RATE_POSITION;
         count_pos_ff   <= tlfp_pkg::RST_COUNT_POSITION;
      end else if (csr_write) begin
         case (csr_index)
            tlfp_pkg::CSR_START_BYTE:     start_byte_ff  <= csr_data;
            tlfp_pkg::CSR_LED_CODE:       led_code_ff    <= csr_data;
            tlfp_pkg::CSR_STATUS_CODE:    status_code_ff <= csr_data;
            tlfp_pkg::CSR_SERIAL_CODE:    serial_code_ff <= csr_data;
            tlfp_pkg::CSR_LED_LENGTH:     led_length_ff  <= csr_data[4:0];
            tlfp_pkg::CSR_RATE_POSITION:  rate_pos_ff    <= csr_data[3:0];
            tlfp_pkg::CSR_COUNT_POSITION: count_pos_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign fill_nxt = fill_ff + 5'd1;
   assign idx_nxt  = idx_ff + 5'd1;

   assign rate_pos_ok  = ({1'b0, rate_pos_ff} < expected_ff) &&
                         (32'(rate_pos_ff) < MAX_PAYLOAD);
   assign count_pos_ok = ({1'b0, count_pos_ff} < expected_ff) &&
                         (32'(count_pos_ff) < MAX_PAYLOAD);

   always_comb begin
      sts.is_start   = (rx_byte == start_byte_ff);
      sts.held_led   = (held_code_ff == led_code_ff) || (held_code_ff == serial_code_ff);
      sts.known      = (rx_byte == led_code_ff) || (rx_byte == serial_code_ff) ||
                       (rx_byte == status_code_ff);
      sts.len_zero   = (rx_byte == 8'd0);
      sts.len_ok     = sts.held_led ?
                       ((rx_byte == {3'b000, led_length_ff}) &&
                        (32'(rx_byte) <= MAX_PAYLOAD)) :
                       sts.len_zero;
      sts.frame_done = (fill_nxt >= expected_ff);
      sts.chk_ok     = rate_ok_ff && count_pos_ok && (rdata_ff != 8'd0);
      sts.idx_last   = (idx_nxt == expected_ff);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      held_code_in = held_code_ff;
      expected_in  = expected_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      if (cmd.take_code) held_code_in = rx_byte;
      if (cmd.take_len) begin
         expected_in = rx_byte[4:0];
         fill_in     = 5'd0;
      end
      if (cmd.write_byte) fill_in = fill_nxt;
      if (cmd.idx_clr)    idx_in  = 5'd0;
      if (cmd.idx_inc)    idx_in  = idx_nxt;
      if (cmd.clear) begin
         held_code_in = 8'd0;
         expected_in  = 5'd0;
         fill_in      = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff <= 8'd0;
         expected_ff  <= 5'd0;
         fill_ff      <= 5'd0;
         idx_ff       <= 5'd0;
      end else begin
         held_code_ff <= held_code_in;
         expected_ff  <= expected_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         tlfp_pkg::RD_RATE:  rd_addr = {1'b0, rate_pos_ff};
         tlfp_pkg::RD_COUNT: rd_addr = {1'b0, count_pos_ff};
         tlfp_pkg::RD_EMIT:  rd_addr = idx_ff;
         default:            rd_addr = idx_ff;
      endcase
   end

   // Payload buffer; out-of-range positions are masked by the position checks
   always_ff @(posedge clock) begin
      if (cmd.write_byte && (32'(fill_ff) < DEPTH)) begin
         mem[fill_ff[AW-1:0]] <= rx_byte;
      end
      if (cmd.rd_en && (32'(rd_addr) < DEPTH)) begin
         rdata_ff <= mem[rd_addr[AW-1:0]];
      end
      if (cmd.cap_rate) begin
         rate_ok_ff <= rate_pos_ok && (rdata_ff != 8'd0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load != tlfp_pkg::LD_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.load)
         tlfp_pkg::LD_IDLE, tlfp_pkg::LD_ERROR: begin
            rsp_status_ff <= (cmd.load == tlfp_pkg::LD_ERROR) ?
                             tlfp_pkg::RSP_ERROR : tlfp_pkg::RSP_NONE;
            rsp_code_ff   <= 8'd0;
            rsp_len_ff    <= 5'd0;
            rsp_idx_ff    <= 4'd0;
            rsp_byte_ff   <= 8'd0;
            rsp_last_ff   <= 1'b1;
         end
         tlfp_pkg::LD_EMPTY: begin
            rsp_status_ff <= tlfp_pkg::RSP_ACCEPT;
            rsp_code_ff   <= held_code_ff;
            rsp_len_ff    <= 5'd0;
            rsp_idx_ff    <= 4'd0;
            rsp_byte_ff   <= 8'd0;
            rsp_last_ff   <= 1'b1;
         end
         tlfp_pkg::LD_BYTE: begin
            rsp_status_ff <= tlfp_pkg::RSP_ACCEPT;
            rsp_code_ff   <= held_code_ff;
            rsp_len_ff    <= expected_ff;
            rsp_idx_ff    <= idx_ff[3:0];
            rsp_byte_ff   <= rdata_ff;
            rsp_last_ff   <= sts.idx_last;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_message_code = rsp_code_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* hdl/tlfp_ctrl.sv */
// ----------------------------------------------------------------------------
// tlfp_ctrl
// Controller: frame phase tracking, payload checks and result sequencing.
// ----------------------------------------------------------------------------
module tlfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tlfp_pkg::sts_type   sts,
   output tlfp_pkg::cmd_type   cmd
);

   tlfp_pkg::state_type state_ff, state_in;
   logic                in_phase;
   logic                accept;

   assign in_phase  = state_ff inside {tlfp_pkg::ST_HUNT, tlfp_pkg::ST_CODE,
                                       tlfp_pkg::ST_LEN, tlfp_pkg::ST_DATA};
   assign req_stall = !(in_phase && sts.out_free);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlfp_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlfp_pkg::ST_HUNT: begin
            if (accept && sts.is_start) state_in = tlfp_pkg::ST_CODE;
         end
         tlfp_pkg::ST_CODE: begin
            if (accept) begin
               if (sts.known)          state_in = tlfp_pkg::ST_LEN;
               else if (!sts.is_start) state_in = tlfp_pkg::ST_HUNT;
            end
         end
         tlfp_pkg::ST_LEN: begin
            if (accept) begin
               if (!sts.len_ok || sts.len_zero) state_in = tlfp_pkg::ST_HUNT;
               else                             state_in = tlfp_pkg::ST_DATA;
            end
         end
         tlfp_pkg::ST_DATA: begin
            if (accept && sts.frame_done) begin
               state_in = sts.held_led ? tlfp_pkg::ST_CHK_RATE : tlfp_pkg::ST_HUNT;
            end
         end
         tlfp_pkg::ST_CHK_RATE:  state_in = tlfp_pkg::ST_CHK_COUNT;
         tlfp_pkg::ST_CHK_COUNT: state_in = tlfp_pkg::ST_CHK_END;
         tlfp_pkg::ST_CHK_END: begin
            if (sts.out_free) begin
               state_in = sts.chk_ok ? tlfp_pkg::ST_EMIT_RD : tlfp_pkg::ST_HUNT;
            end
         end
         tlfp_pkg::ST_EMIT_RD: state_in = tlfp_pkg::ST_EMIT_LD;
         tlfp_pkg::ST_EMIT_LD: begin
            if (sts.out_free) begin
               state_in = sts.idx_last ? tlfp_pkg::ST_HUNT : tlfp_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = tlfp_pkg::ST_HUNT;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = tlfp_pkg::RD_EMIT;
      cmd.load   = tlfp_pkg::LD_NONE;
      case (state_ff)
         tlfp_pkg::ST_HUNT: begin
            if (accept) cmd.load = tlfp_pkg::LD_IDLE;
         end
         tlfp_pkg::ST_CODE: begin
            if (accept) begin
               if (sts.known) begin
                  cmd.take_code = 1'b1;
                  cmd.load      = tlfp_pkg::LD_IDLE;
               end else if (sts.is_start) begin
                  cmd.load = tlfp_pkg::LD_IDLE;
               end else begin
                  cmd.clear = 1'b1;
                  cmd.load  = tlfp_pkg::LD_ERROR;
               end
            end
         end
         tlfp_pkg::ST_LEN: begin
            if (accept) begin
               if (!sts.len_ok) begin
                  cmd.clear = 1'b1;
                  cmd.load  = tlfp_pkg::LD_ERROR;
               end else if (sts.len_zero) begin
                  // zero-length frame completes here; LED-style lacks its checked bytes
                  cmd.clear = 1'b1;
                  cmd.load  = sts.held_led ? tlfp_pkg::LD_ERROR : tlfp_pkg::LD_EMPTY;
               end else begin
                  cmd.take_len = 1'b1;
                  cmd.load     = tlfp_pkg::LD_IDLE;
               end
            end
         end
         tlfp_pkg::ST_DATA: begin
            if (accept) begin
               cmd.write_byte = 1'b1;
               if (!sts.frame_done) begin
                  cmd.load = tlfp_pkg::LD_IDLE;
               end else if (!sts.held_led) begin
                  cmd.clear = 1'b1;
                  cmd.load  = tlfp_pkg::LD_ERROR;
               end
            end
         end
         tlfp_pkg::ST_CHK_RATE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tlfp_pkg::RD_RATE;
         end
         tlfp_pkg::ST_CHK_COUNT: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = tlfp_pkg::RD_COUNT;
            cmd.cap_rate = 1'b1;
         end
         tlfp_pkg::ST_CHK_END: begin
            if (sts.out_free) begin
               if (sts.chk_ok) begin
                  cmd.idx_clr = 1'b1;
               end else begin
                  cmd.clear = 1'b1;
                  cmd.load  = tlfp_pkg::LD_ERROR;
               end
            end
         end
         tlfp_pkg::ST_EMIT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tlfp_pkg::RD_EMIT;
         end
         tlfp_pkg::ST_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.load = tlfp_pkg::LD_BYTE;
               if (sts.idx_last) cmd.clear   = 1'b1;
               else              cmd.idx_inc = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

/* hdl/typed_length_frame_parser.sv */
// A byte that leaves a frame open gives its status result in the cycle after acceptance.
// A completed LED-style frame runs its buffer checks, then a read and a load state per payload
// result, all paced by the single read port of the payload buffer; the next request waits.
// Other requests: one per cycle while the result side keeps up.
// Reset (synchronous): configuration registers back to defaults, parser hunting; buffer not cleared.
// ----------------------------------------------------------------------------
// typed_length_frame_parser
// Parses start / code / length / payload frames from a byte stream and
// reports per-byte status or the payload of each accepted frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module typed_length_frame_parser #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [tlfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlfp_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_message_code,
   output logic [4:0]                      rsp_frame_length,
   output logic [3:0]                      rsp_byte_index,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last
);

   tlfp_pkg::cmd_type cmd;
   tlfp_pkg::sts_type sts;

   tlfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlfp_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rx_byte          (req_rx_byte),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_message_code (rsp_message_code),
      .rsp_frame_length (rsp_frame_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   `TLFP_ASSERT_IMP(a_req_needs_room, req_valid && !req_stall, !rsp_valid || !rsp_stall, "request taken while result register blocked")
   `TLFP_ASSERT_IMP(a_load_needs_room, cmd.load != tlfp_pkg::LD_NONE, sts.out_free, "result loaded over a pending one")
   `TLFP_ASSERT_NXT(a_error_shown, cmd.load == tlfp_pkg::LD_ERROR, rsp_valid && rsp_status == tlfp_pkg::RSP_ERROR, "error result not presented")
   `TLFP_ASSERT_IMP(a_mid_is_payload, rsp_valid && !rsp_last, rsp_status == tlfp_pkg::RSP_ACCEPT, "non-final result outside an accepted frame")
   `TLFP_ASSERT_IMP(a_status_blank, rsp_valid && rsp_status != tlfp_pkg::RSP_ACCEPT, rsp_message_code == 8'd0 && rsp_frame_length == 5'd0, "status result carries frame fields")

endmodule
